[hw/rtl/ttsc_pkg.sv]
// ----------------------------------------------------------------------------
// ttsc_pkg: text to segment column frame, shared types and font
// Types, constants and the seven-segment font used by the lanes and merge.
// ----------------------------------------------------------------------------
package ttsc_pkg;

	localparam int LANES = 8;

	typedef logic [6:0] char_t;
	typedef logic [7:0] glyph_t;
	typedef logic [2:0] seg_t;
	typedef logic [3:0] addr_t;

	localparam glyph_t ERR_GLYPH      = 8'h92;
	localparam glyph_t DP_FORCED      = 8'h8F;
	localparam glyph_t DP_RESET       = 8'h08;
	localparam glyph_t DIGIT_EN_RESET = 8'hFF;
	localparam seg_t   SEG_LAST       = 3'd7;

	function automatic glyph_t font_lookup(input char_t code);
		glyph_t g;
		case (code)
			7'd32:   g = 8'h00;
			7'd45:   g = 8'h02;
			7'd48:   g = 8'hFC;
			7'd49:   g = 8'h60;
			7'd50:   g = 8'hDA;
			7'd51:   g = 8'hF2;
			7'd52:   g = 8'h66;
			7'd53:   g = 8'hB6;
			7'd54:   g = 8'hBE;
			7'd55:   g = 8'hE0;
			7'd56:   g = 8'hFE;
			7'd57:   g = 8'hE6;
			7'd61:   g = 8'h12;
			7'd65:   g = 8'hEE;
			7'd66:   g = 8'h3E;
			7'd67:   g = 8'h9C;
			7'd68:   g = 8'h7A;
			7'd69:   g = 8'h9E;
			7'd70:   g = 8'h8E;
			7'd72:   g = 8'h6E;
			7'd73:   g = 8'h0C;
			7'd76:   g = 8'h1C;
			7'd78:   g = 8'h2A;
			7'd79:   g = 8'hFC;
			7'd80:   g = 8'hCE;
			7'd82:   g = 8'h0A;
			7'd83:   g = 8'hB6;
			7'd84:   g = 8'h1E;
			7'd85:   g = 8'h7C;
			7'd89:   g = 8'h76;
			7'd94:   g = 8'hC6;
			7'd95:   g = 8'h10;
			7'd97:   g = 8'hEE;
			7'd98:   g = 8'h3E;
			7'd99:   g = 8'h1A;
			7'd100:  g = 8'h7A;
			7'd101:  g = 8'h9E;
			7'd102:  g = 8'h8E;
			7'd104:  g = 8'h2E;
			7'd105:  g = 8'h0C;
			7'd108:  g = 8'h1C;
			7'd110:  g = 8'h2A;
			7'd111:  g = 8'h3A;
			7'd112:  g = 8'hCE;
			7'd114:  g = 8'h0A;
			7'd115:  g = 8'hB6;
			7'd116:  g = 8'h1E;
			7'd117:  g = 8'h38;
			7'd121:  g = 8'h76;
			default: g = ERR_GLYPH;
		endcase
		return g;
	endfunction

endpackage

[hw/rtl/ttsc_lane.sv]
// ----------------------------------------------------------------------------
// ttsc_lane: one digit lane
// Looks up one character in the font and blanks it when its digit is off.
// ----------------------------------------------------------------------------
module ttsc_lane (
	input  logic           clk,
	input  logic           load,
	input  ttsc_pkg::char_t code,
	input  logic           enable,
	output ttsc_pkg::glyph_t glyph_s1
);
	import ttsc_pkg::*;

	always_ff @(posedge clk) begin
		if (load) begin
			glyph_s1 <= font_lookup(code) & {$bits(glyph_t){enable}};
		end
	end

endmodule

[hw/rtl/ttsc_merge.sv]
// ----------------------------------------------------------------------------
// ttsc_merge: column merge and register write sequencer
// Transposes lane glyphs to segment columns, sent one a cycle unless stalled.
// ----------------------------------------------------------------------------
module ttsc_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  ttsc_pkg::glyph_t  glyph_s1 [ttsc_pkg::LANES],
	input  ttsc_pkg::glyph_t  dp_s1,
	output logic              frame_load,
	output logic              out_valid,
	input  logic              out_stall,
	output ttsc_pkg::addr_t   reg_address,
	output ttsc_pkg::glyph_t  reg_data,
	output logic              last
);
	import ttsc_pkg::*;

	glyph_t col      [LANES];
	glyph_t frame_q  [LANES];
	seg_t   seg_q;
	logic   busy_q;
	logic   out_xfer;

	assign out_xfer   = busy_q && !out_stall;
	assign frame_load = valid_s1 && (!busy_q || (out_xfer && seg_q == SEG_LAST));

	always_comb begin
		for (int s = 0; s < LANES; s++) begin
			for (int d = 0; d < LANES; d++) begin
				col[s][d] = glyph_s1[d][LANES - 1 - s];
			end
		end
		col[LANES - 1] = col[LANES - 1] | dp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= '0;
		end else if (frame_load) begin
			busy_q <= 1'b1;
			seg_q  <= '0;
		end else if (out_xfer) begin
			if (seg_q == SEG_LAST) begin
				busy_q <= 1'b0;
			end
			seg_q <= seg_q + seg_t'(1);
		end
	end

	// shift the frame down one column per transfer
	always_ff @(posedge clk) begin
		if (frame_load) begin
			frame_q <= col;
		end else if (out_xfer) begin
			for (int i = 0; i < LANES - 1; i++) begin
				frame_q[i] <= frame_q[i + 1];
			end
		end
	end

	assign out_valid   = busy_q;
	assign reg_address = {1'b0, seg_q} + addr_t'(1);
	assign reg_data    = frame_q[0];
	assign last        = (seg_q == SEG_LAST);

endmodule

[hw/rtl/text_to_segment_column_frame_unit.sv]
// ----------------------------------------------------------------------------
// text_to_segment_column_frame_unit: text frame to segment register writes
// Encodes eight characters into eight segment-column register writes.
// ----------------------------------------------------------------------------
// Each input transfer carries eight character codes and a decimal-point
// request; eight lanes look the characters up in the font at once, and the
// merge stage transposes the glyphs into eight register writes (addresses 1
// to 8, last set on the eighth) that leave one per cycle unless out_stall is
// high. Each item passes the lane registers and then the merge frame register
// before its first write appears. A frame holds the output channel for its
// eight writes; the next item is taken and held in the lane registers while
// the current frame drains. digit_enable is sampled when an item is taken.
module text_to_segment_column_frame_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              dp_force,
	input  ttsc_pkg::char_t   char_0,
	input  ttsc_pkg::char_t   char_1,
	input  ttsc_pkg::char_t   char_2,
	input  ttsc_pkg::char_t   char_3,
	input  ttsc_pkg::char_t   char_4,
	input  ttsc_pkg::char_t   char_5,
	input  ttsc_pkg::char_t   char_6,
	input  ttsc_pkg::char_t   char_7,
	input  logic              cfg_we,
	input  ttsc_pkg::glyph_t  cfg_wdata,
	output logic              out_valid,
	input  logic              out_stall,
	output ttsc_pkg::addr_t   reg_address,
	output ttsc_pkg::glyph_t  reg_data,
	output logic              last
);
	import ttsc_pkg::*;

	glyph_t digit_enable_q;
	glyph_t dp_mask_q;
	glyph_t dp_next;
	glyph_t dp_s1;
	glyph_t glyph_s1 [LANES];
	char_t  char_a   [LANES];
	logic   valid_s1;
	logic   in_take;
	logic   frame_load;

	assign in_stall = valid_s1 && !frame_load;
	assign in_take  = in_valid && !in_stall;
	assign dp_next  = dp_force ? DP_FORCED : dp_mask_q;

	// digit d shows char_(7-d)
	assign char_a[0] = char_7;
	assign char_a[1] = char_6;
	assign char_a[2] = char_5;
	assign char_a[3] = char_4;
	assign char_a[4] = char_3;
	assign char_a[5] = char_2;
	assign char_a[6] = char_1;
	assign char_a[7] = char_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_enable_q <= DIGIT_EN_RESET;
			dp_mask_q      <= DP_RESET;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				digit_enable_q <= cfg_wdata;
			end
			if (in_take) begin
				dp_mask_q <= dp_next;
				valid_s1  <= 1'b1;
			end else if (frame_load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			dp_s1 <= dp_next;
		end
	end

	for (genvar d = 0; d < LANES; d++) begin : g_lane
		ttsc_lane u_lane (
			.clk      (clk),
			.load     (in_take),
			.code     (char_a[d]),
			.enable   (digit_enable_q[d]),
			.glyph_s1 (glyph_s1[d])
		);
	end

	ttsc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.glyph_s1    (glyph_s1),
		.dp_s1       (dp_s1),
		.frame_load  (frame_load),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last        (last)
	);

endmodule

[hw/rtl/ttsc_checker.sv]
// ----------------------------------------------------------------------------
// ttsc_checker: port-level checks for the text to segment frame unit
// Watches the output write sequence and the input stall behaviour.
// ----------------------------------------------------------------------------
module ttsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] reg_address,
	input logic [7:0] reg_data,
	input logic       last
);

	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> reg_address == 4'd8)
		else $error("last write not at address 8");

	a_addr_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && reg_address == $past(reg_address) + 4'd1)
		else $error("write sequence broken inside a frame");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> reg_address == 4'd1)
		else $error("frame does not start at address 1");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is idle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reg_data))
		else $error("stalled write changed");

endmodule

bind text_to_segment_column_frame_unit ttsc_checker u_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: text to segment column frame unit
// Drives eight-character frames with random gaps, checks each register write
// against a local font and transpose model, under several digit-enable masks.
// ----------------------------------------------------------------------------
module tb;

	import ttsc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 80;
	localparam char_t CH_SPACE = 7'd32;

	// seven-segment font, index is the character code
	localparam logic [0:127][7:0] SEG_FONT = {
		8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92,
		8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92,
		8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92,
		8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92,
		8'h00, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92,
		8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h02, 8'h92, 8'h92,
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
		8'hFE, 8'hE6, 8'h92, 8'h92, 8'h92, 8'h12, 8'h92, 8'h92,
		8'h92, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E, 8'h92,
		8'h6E, 8'h0C, 8'h92, 8'h92, 8'h1C, 8'h92, 8'h2A, 8'hFC,
		8'hCE, 8'h92, 8'h0A, 8'hB6, 8'h1E, 8'h7C, 8'h92, 8'h92,
		8'h92, 8'h76, 8'h92, 8'h92, 8'h92, 8'h92, 8'hC6, 8'h10,
		8'h92, 8'hEE, 8'h3E, 8'h1A, 8'h7A, 8'h9E, 8'h8E, 8'h92,
		8'h2E, 8'h0C, 8'h92, 8'h92, 8'h1C, 8'h92, 8'h2A, 8'h3A,
		8'hCE, 8'h92, 8'h0A, 8'hB6, 8'h1E, 8'h38, 8'h92, 8'h92,
		8'h92, 8'h76, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92, 8'h92
	};

	typedef struct packed {
		logic             dp;
		char_t [7:0]      chars;
	} frame_t;

	typedef struct packed {
		addr_t   address;
		glyph_t  data;
		logic    last;
	} column_write_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    in_valid = 1'b0;
	logic    in_stall;
	logic    dp_force = 1'b0;
	char_t   char_0 = '0;
	char_t   char_1 = '0;
	char_t   char_2 = '0;
	char_t   char_3 = '0;
	char_t   char_4 = '0;
	char_t   char_5 = '0;
	char_t   char_6 = '0;
	char_t   char_7 = '0;
	logic    cfg_we = 1'b0;
	glyph_t  cfg_wdata = '0;
	logic    out_valid;
	logic    out_stall = 1'b0;
	addr_t   reg_address;
	glyph_t  reg_data;
	logic    last;

	text_to_segment_column_frame_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dp_force    (dp_force),
		.char_0      (char_0),
		.char_1      (char_1),
		.char_2      (char_2),
		.char_3      (char_3),
		.char_4      (char_4),
		.char_5      (char_5),
		.char_6      (char_6),
		.char_7      (char_7),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last        (last)
	);

	always #10 clk = ~clk;

	frame_t         frame_queue [$];
	column_write_t  column_writes_due [$];
	glyph_t         digit_en_model = DIGIT_EN_RESET;
	glyph_t         dp_mask_model = DP_RESET;

	bit           send_idle = 1'b1;
	bit           recv_idle = 1'b1;
	int unsigned  hold_reqs = 0;
	int unsigned  frames_sent = 0;
	int unsigned  writes_checked = 0;
	int unsigned  settings_used = 0;
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;

	function automatic void encode_frame(input frame_t f);
		glyph_t glyph [8];
		glyph_t data;
		column_write_t w;
		int seg_bit;
		if (f.dp)
			dp_mask_model = DP_FORCED;
		for (int d = 0; d < 8; d++)
			glyph[d] = SEG_FONT[f.chars[7 - d]];
		for (int s = 0; s < 8; s++) begin
			seg_bit = 7 - s;
			data = '0;
			for (int d = 0; d < 8; d++)
				data[d] = glyph[d][seg_bit] & digit_en_model[d];
			if (s == int'(SEG_LAST))
				data = data | dp_mask_model;
			w.address = addr_t'(s + 1);
			w.data = data;
			w.last = (s == int'(SEG_LAST));
			column_writes_due.push_back(w);
		end
	endfunction

	function automatic frame_t text_frame(input string s, input bit dp);
		frame_t f;
		f.dp = dp;
		for (int k = 0; k < 8; k++)
			f.chars[k] = char_t'(s[k]);
		return f;
	endfunction

	function automatic frame_t fill_frame(input char_t c, input bit dp);
		frame_t f;
		f.dp = dp;
		for (int k = 0; k < 8; k++)
			f.chars[k] = c;
		return f;
	endfunction

	function automatic char_t pick_char();
		int r;
		char_t c;
		r = $urandom_range(0, 19);
		if (r < 3) begin
			c = CH_SPACE;
		end else if (r < 11) begin
			c = char_t'($urandom_range(45, 121));
			while (SEG_FONT[c] == ERR_GLYPH)
				c = char_t'($urandom_range(45, 121));
		end else begin
			c = char_t'($urandom_range(0, 127));
		end
		return c;
	endfunction

	function automatic frame_t random_frame(input bit dp);
		frame_t f;
		f.dp = dp;
		for (int k = 0; k < 8; k++)
			f.chars[k] = pick_char();
		return f;
	endfunction

	task automatic wait_idle();
		while (frame_queue.size() != 0 || in_valid || column_writes_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_digit_enable(input glyph_t v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		digit_en_model = v;
		settings_used++;
		@(negedge clk);
	endtask

	// sender: hold the payload until the transfer, then draw the next gap
	frame_t       held;
	bit           offering = 1'b0;
	int unsigned  gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			offering = 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				encode_frame(held);
				frames_sent++;
				offering = 1'b0;
				gap_left = send_idle ? $urandom_range(0, 3) : 0;
			end
			if (!offering) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (frame_queue.size() != 0) begin
					held = frame_queue.pop_front();
					offering = 1'b1;
				end
			end
			in_valid <= offering;
			dp_force <= held.dp;
			char_0 <= held.chars[0];
			char_1 <= held.chars[1];
			char_2 <= held.chars[2];
			char_3 <= held.chars[3];
			char_4 <= held.chars[4];
			char_5 <= held.chars[5];
			char_6 <= held.chars[6];
			char_7 <= held.chars[7];
		end
	end

	// receiver: check each transfer, then draw a stall or serve a long hold
	column_write_t  due;
	int unsigned    wait_left = 0;
	int unsigned    hold_left = 0;
	int unsigned    hold_seen = 0;
	bit             stall_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			wait_left = 0;
			hold_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (column_writes_due.size() == 0) begin
					$error("unexpected write: reg_address %0d reg_data %02h last %0b",
						reg_address, reg_data, last);
					mismatches++;
				end else begin
					due = column_writes_due.pop_front();
					writes_checked++;
					if (reg_address !== due.address) begin
						$error("reg_address: expected %0d, got %0d", due.address, reg_address);
						mismatches++;
					end
					if (reg_data !== due.data) begin
						$error("reg_data: expected %02h, got %02h", due.data, reg_data);
						mismatches++;
					end
					if (last !== due.last) begin
						$error("last: expected %0b, got %0b", due.last, last);
						mismatches++;
					end
				end
				wait_left = recv_idle ? $urandom_range(0, 3) : 0;
			end
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (wait_left != 0) begin
				wait_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			out_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		bit dp;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// font coverage with every digit enabled, point mask still at reset
		set_digit_enable(DIGIT_EN_RESET);
		frame_queue.push_back(fill_frame(7'd0, 1'b0));
		frame_queue.push_back(fill_frame(7'd127, 1'b0));
		frame_queue.push_back(fill_frame(CH_SPACE, 1'b0));
		frame_queue.push_back(text_frame("01234567", 1'b0));
		frame_queue.push_back(text_frame("89-=ABCD", 1'b0));
		frame_queue.push_back(text_frame("EFHILNOP", 1'b0));
		frame_queue.push_back(text_frame("RSTUY^_a", 1'b0));
		frame_queue.push_back(text_frame("bcdefhil", 1'b0));
		frame_queue.push_back(text_frame("noprstuy", 1'b0));
		frame_queue.push_back(text_frame("!:@G#z~|", 1'b0));
		frame_queue.push_back(text_frame("U*U*U*U*", 1'b0));
		frame_queue.push_back(text_frame("*U*U*U*U", 1'b0));
		frame_queue.push_back(text_frame("8 8 8 8 ", 1'b0));
		wait_idle();

		// blanked and single-digit masks
		set_digit_enable(8'h00);
		frame_queue.push_back(text_frame("88888888", 1'b0));
		frame_queue.push_back(fill_frame(7'd127, 1'b0));
		wait_idle();
		set_digit_enable(8'h01);
		frame_queue.push_back(text_frame("88888888", 1'b0));
		wait_idle();
		set_digit_enable(8'h80);
		frame_queue.push_back(text_frame("88888888", 1'b0));
		wait_idle();

		for (int p = 0; p < 10; p++) begin
			case (p)
				1, 6:    set_digit_enable(8'hFF);
				3:       set_digit_enable(8'h00);
				default: set_digit_enable(glyph_t'($urandom_range(0, 255)));
			endcase
			send_idle = (p % 3 != 0);
			recv_idle = (p % 3 != 0);
			if (p == 2)
				hold_reqs++;
			for (int i = 0; i < 23; i++) begin
				if (p < 4)
					dp = 1'b0;
				else if (p == 4 && i == 0)
					dp = 1'b1;
				else
					dp = ($urandom_range(0, 3) == 0);
				frame_queue.push_back(random_frame(dp));
				// drain the pipeline halfway through one phase
				if (p == 5 && i == 11)
					wait_idle();
			end
			wait_idle();
		end

		repeat (20) @(negedge clk);
		$display("tb: %0d frames sent, %0d register writes checked", frames_sent, writes_checked);
		$display("tb: %0d digit-enable settings, point mask before and after forcing",
			settings_used);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ttsc_pkg.sv
hw/rtl/ttsc_lane.sv
hw/rtl/ttsc_merge.sv
hw/rtl/text_to_segment_column_frame_unit.sv
hw/rtl/ttsc_checker.sv
sim/tb.sv
